// ===== hdl/fsp_pkg.sv =====
// shared types, character codes and helpers for the format specifier parser
`timescale 1ns / 1ps

package fsp_pkg;

    localparam int FSP_QUEUE_DEPTH = 4;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LOW_H  = 8'h68;
    localparam logic [7:0] CH_LOW_L  = 8'h6C;
    localparam logic [7:0] CH_UP_L   = 8'h4C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [8:0] FB_RIGHT  = 9'h001;
    localparam logic [8:0] FB_BLANK  = 9'h002;
    localparam logic [8:0] FB_SIGN   = 9'h004;
    localparam logic [8:0] FB_ZERO   = 9'h008;
    localparam logic [8:0] FB_ALT    = 9'h010;
    localparam logic [8:0] FB_NEEDW  = 9'h020;
    localparam logic [8:0] FB_NEGP   = 9'h040;
    localparam logic [8:0] FB_NEEDP  = 9'h080;
    localparam logic [8:0] FB_NOPREC = 9'h100;

    localparam logic [3:0] SB_SHORT = 4'h1;
    localparam logic [3:0] SB_BYTE  = 4'h2;
    localparam logic [3:0] SB_LONG  = 4'h4;
    localparam logic [3:0] SB_XLONG = 4'h8;

    localparam logic RK_KEY = 1'b0;
    localparam logic RK_SET = 1'b1;

    typedef enum logic [2:0] {
        PH_FLAG  = 3'd0,
        PH_WIDTH = 3'd1,
        PH_DOT   = 3'd2,
        PH_NEG   = 3'd3,
        PH_PDIG  = 3'd4,
        PH_SIZE  = 3'd5,
        PH_SET   = 3'd6
    } phase_t;

    // what the back end must emit for one item
    typedef enum logic [1:0] {
        OP_KEY      = 2'd0,  // key result
        OP_SET      = 2'd1,  // one set byte
        OP_SET_PAIR = 2'd2,  // backslash, then set byte
        OP_SET_KEY  = 2'd3   // backslash, then key result
    } op_kind_t;

    typedef struct packed {
        op_kind_t    op;
        logic [7:0]  conversion;
        logic [8:0]  flag_bits;
        logic [3:0]  size_bits;
        logic [15:0] field_width;
        logic [15:0] precision;
        logic [15:0] consumed_count;
        logic [7:0]  set_byte;
    } entry_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  conversion;
        logic [8:0]  flag_bits;
        logic [3:0]  size_bits;
        logic [15:0] field_width;
        logic [15:0] precision;
        logic [15:0] consumed_count;
        logic [7:0]  set_byte;
        logic        last;
    } result_t;

    // acc * 10 + d, clamped to 16 bits
    function automatic logic [15:0] sat_digit(input logic [15:0] acc, input logic [3:0] d);
        logic [19:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'h0000, d};
        return (v > {4'h0, SAT16}) ? SAT16 : v[15:0];
    endfunction

    function automatic result_t set_result(input logic [7:0] b);
        result_t r;
        r = '0;
        r.result_kind = RK_SET;
        r.set_byte = b;
        return r;
    endfunction

    function automatic result_t key_result(input entry_t e);
        result_t r;
        r.result_kind    = RK_KEY;
        r.conversion     = e.conversion;
        r.flag_bits      = e.flag_bits;
        r.size_bits      = e.size_bits;
        r.field_width    = e.field_width;
        r.precision      = e.precision;
        r.consumed_count = e.consumed_count;
        r.set_byte       = 8'h00;
        r.last           = 1'b1;
        return r;
    endfunction

endpackage

// ===== hdl/format_spec_parser_unit.sv =====
// top level of the printf format specifier parser
// an item's operation is queued, then its result is loaded into the output register
// throughput: one input item per cycle while the queue is not full; an item with two
//   results holds the output register for both, and the four-entry queue absorbs that
// reset: synchronous active-low aresetn returns the parser to the flag phase and
//   empties the queue and output register; no clearing pass is needed
`timescale 1ns / 1ps

module format_spec_parser_unit
    import fsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = FSP_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_input_byte,
    input  logic        s_end_of_input,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [7:0]  m_conversion,
    output logic [8:0]  m_flag_bits,
    output logic [3:0]  m_size_bits,
    output logic [15:0] m_field_width,
    output logic [15:0] m_precision,
    output logic [15:0] m_consumed_count,
    output logic [7:0]  m_set_byte,
    output logic        m_last
);

    logic    q_full;
    logic    q_push;
    entry_t  q_push_entry;
    logic    q_pop;
    logic    q_not_empty;
    entry_t  q_head;
    result_t result;

    fsp_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_input_byte   (s_input_byte),
        .s_end_of_input (s_end_of_input),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (q_push_entry)
    );

    fsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    fsp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (result)
    );

    assign m_result_kind    = result.result_kind;
    assign m_conversion     = result.conversion;
    assign m_flag_bits      = result.flag_bits;
    assign m_size_bits      = result.size_bits;
    assign m_field_width    = result.field_width;
    assign m_precision      = result.precision;
    assign m_consumed_count = result.consumed_count;
    assign m_set_byte       = result.set_byte;
    assign m_last           = result.last;

endmodule

// ===== hdl/fsp_front.sv =====
// front end: accepts bytes, tracks the key phase and queues output operations
`timescale 1ns / 1ps

module fsp_front
    import fsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_input_byte,
    input  logic       s_end_of_input,
    input  logic       q_full,
    output logic       q_push,
    output entry_t     q_entry
);

    phase_t      phase_reg, phase_next;
    logic [8:0]  flags_reg, flags_next;
    logic [3:0]  size_reg, size_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] prec_reg, prec_next;
    logic [15:0] count_reg, count_next;
    logic        esc_reg, esc_next;

    phase_t      w_phase;
    logic [8:0]  w_flags;
    logic [3:0]  w_size;
    logic [15:0] w_width;
    logic [15:0] w_prec;
    logic [15:0] w_count;
    logic        w_esc;
    logic        done;
    logic        op_valid;
    op_kind_t    op_kind;
    logic [7:0]  op_conv;
    logic [7:0]  op_byte;

    logic [7:0]  ch;
    logic        digit;
    logic [15:0] count_inc;
    logic        accept;

    assign ch        = s_input_byte;
    assign digit     = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign count_inc = (count_reg == SAT16) ? count_reg : count_reg + 16'd1;
    assign accept    = s_valid && s_ready;

    // parse one byte, or the end of input, against the current phase, falling through phases
    always_comb begin
        w_phase  = phase_reg;
        w_flags  = flags_reg;
        w_size   = size_reg;
        w_width  = width_reg;
        w_prec   = prec_reg;
        w_count  = count_reg;
        w_esc    = esc_reg;
        done     = 1'b0;
        op_valid = 1'b0;
        op_kind  = OP_KEY;
        op_conv  = 8'h00;
        op_byte  = 8'h00;
        if (s_end_of_input) begin
            op_valid = 1'b1;
            if (phase_reg == PH_SET) begin
                op_kind = esc_reg ? OP_SET_KEY : OP_KEY;
                op_conv = CH_LBRACK;
            end else if (phase_reg == PH_FLAG || phase_reg == PH_WIDTH ||
                         phase_reg == PH_DOT) begin
                w_flags = flags_reg | FB_NOPREC;
            end
        end else begin
            w_count = count_inc;
            if (phase_reg == PH_SET) begin
                done = 1'b1;
                if (esc_reg) begin
                    w_esc    = 1'b0;
                    op_valid = 1'b1;
                    op_byte  = ch;
                    op_kind  = (ch == CH_RBRACK) ? OP_SET : OP_SET_PAIR;
                end else if (ch == CH_BSLASH) begin
                    w_esc = 1'b1;
                end else if (ch == CH_RBRACK) begin
                    op_valid = 1'b1;
                    op_kind  = OP_KEY;
                    op_conv  = CH_LBRACK;
                end else begin
                    op_valid = 1'b1;
                    op_kind  = OP_SET;
                    op_byte  = ch;
                end
            end
            if (!done && w_phase == PH_FLAG) begin
                done = 1'b1;
                priority if (ch == CH_SPACE) w_flags = w_flags | FB_BLANK;
                else if (ch == CH_PLUS)  w_flags = w_flags | FB_SIGN | FB_BLANK;
                else if (ch == CH_MINUS) w_flags = w_flags & ~FB_RIGHT;
                else if (ch == CH_ZERO)  w_flags = w_flags | FB_ZERO;
                else if (ch == CH_HASH)  w_flags = w_flags | FB_ALT;
                else begin
                    done    = 1'b0;
                    w_phase = PH_WIDTH;
                end
            end
            if (!done && w_phase == PH_WIDTH) begin
                if (digit) begin
                    w_width = sat_digit(w_width, ch[3:0]);
                    done    = 1'b1;
                end else begin
                    w_phase = PH_DOT;
                    if (ch == CH_STAR) begin
                        w_flags = w_flags | FB_NEEDW;
                        done    = 1'b1;
                    end
                end
            end
            if (!done && w_phase == PH_DOT) begin
                if (ch == CH_DOT) begin
                    w_phase = PH_NEG;
                    done    = 1'b1;
                end else begin
                    w_flags = w_flags | FB_NOPREC;
                    w_phase = PH_SIZE;
                end
            end
            if (!done && w_phase == PH_NEG) begin
                w_phase = PH_PDIG;
                if (ch == CH_MINUS) begin
                    w_flags = w_flags | FB_NEGP;
                    done    = 1'b1;
                end
            end
            if (!done && w_phase == PH_PDIG) begin
                if (digit) begin
                    w_prec = sat_digit(w_prec, ch[3:0]);
                    done   = 1'b1;
                end else begin
                    w_phase = PH_SIZE;
                    if (ch == CH_STAR) begin
                        w_flags = w_flags | FB_NEEDP;
                        done    = 1'b1;
                    end
                end
            end
            if (!done) begin
                priority if (ch == CH_LOW_H) begin
                    w_size = w_size | ((w_size & SB_SHORT) != 4'h0 ? SB_BYTE : SB_SHORT);
                end else if (ch == CH_LOW_L) begin
                    w_size = w_size | ((w_size & SB_LONG) != 4'h0 ? SB_XLONG : SB_LONG);
                end else if (ch == CH_UP_L) begin
                    w_size = w_size | SB_XLONG;
                end else if (ch == CH_LBRACK) begin
                    w_phase = PH_SET;
                    w_esc   = 1'b0;
                end else begin
                    op_valid = 1'b1;
                    op_kind  = OP_KEY;
                    op_conv  = ch;
                end
            end
        end
    end

    // next state: a finished key returns every field to its reset value
    always_comb begin
        if (op_valid && (op_kind == OP_KEY || op_kind == OP_SET_KEY)) begin
            phase_next = PH_FLAG;
            flags_next = FB_RIGHT;
            size_next  = 4'h0;
            width_next = 16'h0000;
            prec_next  = 16'h0000;
            count_next = 16'h0000;
            esc_next   = 1'b0;
        end else begin
            phase_next = w_phase;
            flags_next = w_flags;
            size_next  = w_size;
            width_next = w_width;
            prec_next  = w_prec;
            count_next = w_count;
            esc_next   = w_esc;
        end
    end

    // outputs toward the queue
    always_comb begin
        s_ready                = !q_full;
        q_push                 = accept && op_valid;
        q_entry.op             = op_kind;
        q_entry.conversion     = op_conv;
        q_entry.flag_bits      = w_flags;
        q_entry.size_bits      = w_size;
        q_entry.field_width    = w_width;
        q_entry.precision      = w_prec;
        q_entry.consumed_count = w_count;
        q_entry.set_byte       = op_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FLAG;
            flags_reg <= FB_RIGHT;
            size_reg  <= 4'h0;
            width_reg <= 16'h0000;
            prec_reg  <= 16'h0000;
            count_reg <= 16'h0000;
            esc_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            size_reg  <= size_next;
            width_reg <= width_next;
            prec_reg  <= prec_next;
            count_reg <= count_next;
            esc_reg   <= esc_next;
        end
    end

endmodule

// ===== hdl/fsp_queue.sv =====
// small queue of pending output operations between front and back end
`timescale 1ns / 1ps

module fsp_queue
    import fsp_pkg::*;
#(
    parameter int DEPTH = FSP_QUEUE_DEPTH  // at least 2
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hdl/fsp_back.sv =====
// back end: expands queued operations into result items on the output register
`timescale 1ns / 1ps

module fsp_back
    import fsp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_not_empty,
    input  entry_t  q_head,
    output logic    q_pop,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg, valid_next;
    logic    pend_reg, pend_next;
    entry_t  entry_reg;
    result_t res_reg, res_next;
    result_t first_res;
    result_t second_res;
    logic    load;

    assign load    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_result = res_reg;

    always_comb begin
        unique case (q_head.op)
            OP_KEY:      first_res = key_result(q_head);
            OP_SET:      first_res = set_result(q_head.set_byte);
            OP_SET_PAIR: first_res = set_result(CH_BSLASH);
            OP_SET_KEY:  first_res = set_result(CH_BSLASH);
            default:     first_res = key_result(q_head);
        endcase
        // only the two-result operations ever reach the second slot
        if (entry_reg.op == OP_SET_KEY) begin
            second_res = key_result(entry_reg);
        end else begin
            second_res = set_result(entry_reg.set_byte);
        end
    end

    always_comb begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        res_next   = res_reg;
        q_pop      = 1'b0;
        if (load) begin
            if (pend_reg) begin
                valid_next = 1'b1;
                pend_next  = 1'b0;
                res_next   = second_res;
            end else if (q_not_empty) begin
                q_pop      = 1'b1;
                valid_next = 1'b1;
                pend_next  = (q_head.op == OP_SET_PAIR) || (q_head.op == OP_SET_KEY);
                res_next   = first_res;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (q_pop) begin
            entry_reg <= q_head;
        end
    end

endmodule
